// ----- hw/rtl/psched_pkg.sv -----
// types, codes and defaults shared by the priority scheduler
`default_nettype none

package psched_pkg;

  localparam int NUM_PRIO_DEF    = 8;
  localparam int MAX_TASKS_DEF   = 8;
  localparam int DELAY_WIDTH_DEF = 32;

  localparam int PRIO_W  = 3;
  localparam int COUNT_W = 4;
  localparam int SW_W    = 32;

  typedef logic [PRIO_W-1:0] idx_t;

  localparam logic [2:0] MODE_CREATE   = 3'd0;
  localparam logic [2:0] MODE_DELAY    = 3'd1;
  localparam logic [2:0] MODE_TICK     = 3'd2;
  localparam logic [2:0] MODE_RESCHED  = 3'd3;
  localparam logic [2:0] MODE_INT_EXIT = 3'd4;
  localparam logic [2:0] MODE_START    = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  task_prio;
    logic [31:0] delay_ticks;
    logic        int_active;
    logic        sched_locked;
  } req_t;

  typedef struct packed {
    logic        switch_needed;
    logic [2:0]  next_prio;
    logic [7:0]  ready_bits;
    logic [1:0]  status;
    logic [31:0] switch_total;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic tick;
    logic found;
    idx_t idx;
  } tok_t;

  typedef struct packed {
    logic set_ready;
    logic clr_ready;
    logic clr_count;
    logic load_count;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/psched_cell.sv -----
// one priority slot: ready bit, delay counter and a stage of the scan chain
`default_nettype none

module psched_cell #(
  parameter int DELAY_WIDTH = psched_pkg::DELAY_WIDTH_DEF,
  parameter int IDX         = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire psched_pkg::cell_cmd_t cmd,
  input  wire logic [DELAY_WIDTH-1:0] load_value,
  input  wire psched_pkg::tok_t      tok_in,
  output psched_pkg::tok_t           tok_out,
  output logic                       ready_bit
);

  logic [DELAY_WIDTH-1:0] count;
  logic                   ready;
  psched_pkg::tok_t       tok;
  psched_pkg::tok_t       tok_next;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.tick && !tok_in.found && ready) begin
      tok_next.found = 1'b1;
      tok_next.idx   = psched_pkg::idx_t'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok   <= '0;
      ready <= 1'b0;
      count <= '0;
    end else begin
      tok <= tok_next;
      if (cmd.set_ready) begin
        ready <= 1'b1;
      end
      if (cmd.clr_ready) begin
        ready <= 1'b0;
      end
      if (cmd.clr_count) begin
        count <= '0;
      end else if (cmd.load_count) begin
        count <= load_value;
      end else if (tok_in.valid && tok_in.tick && count != '0) begin
        count <= count - DELAY_WIDTH'(1);
        if (count == DELAY_WIDTH'(1)) begin
          ready <= 1'b1;
        end
      end
    end
  end

  assign tok_out   = tok;
  assign ready_bit = ready;

endmodule

`default_nettype wire

// ----- hw/rtl/priority_ready_scheduler_top.sv -----
// top level of the bitmap priority scheduler with tick delays
//
//   channel | direction | payload              | transfer when
//   req     | in        | psched_pkg::req_t    | req_valid & req_ready
//   rsp     | out       | psched_pkg::rsp_t    | rsp_valid & rsp_ready
//
// one event at a time; tick, delay, reschedule, interrupt exit and start send a
// token down the row of NUM_PRIO cells before the event finishes; create, zero
// delays and ignored events skip the scan and go from the apply step straight
// to the final step
// the cells form a chain with a token register in each slot
// synchronous reset clears all masks, counters and the switch count
// a held result stalls only the final step; the next event is taken meanwhile
`default_nettype none

module priority_ready_scheduler_top #(
  parameter int NUM_PRIO    = psched_pkg::NUM_PRIO_DEF,
  parameter int MAX_TASKS   = psched_pkg::MAX_TASKS_DEF,
  parameter int DELAY_WIDTH = psched_pkg::DELAY_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire psched_pkg::req_t req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output psched_pkg::rsp_t      rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPLY  = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  localparam logic [1:0] SCAN_TICK   = 2'd0;
  localparam logic [1:0] SCAN_SWITCH = 2'd1;
  localparam logic [1:0] SCAN_START  = 2'd2;

  logic [2:0]                        state;
  logic [2:0]                        mode;
  psched_pkg::idx_t                  prio;
  logic [DELAY_WIDTH-1:0]            ticks;
  logic                              blocked;
  logic [psched_pkg::COUNT_W-1:0]    task_count;
  psched_pkg::idx_t                  current_prio;
  logic                              running;
  logic [psched_pkg::SW_W-1:0]       switch_count;
  logic [1:0]                        status;
  logic                              sw;
  logic [1:0]                        scan_kind;

  logic [1:0]                        apply_status;
  logic                              apply_scan;
  logic [1:0]                        apply_kind;
  logic                              create_ok;
  logic                              delay_ok;
  logic                              start_ok;
  psched_pkg::idx_t                  pick;
  logic                              pick_changes;

  psched_pkg::tok_t                  chain [NUM_PRIO+1];
  psched_pkg::cell_cmd_t             cmd   [NUM_PRIO];
  logic [NUM_PRIO-1:0]               ready_vec;

  always_comb begin
    apply_status = psched_pkg::ST_OK;
    apply_scan   = 1'b0;
    apply_kind   = SCAN_SWITCH;
    create_ok    = 1'b0;
    delay_ok     = 1'b0;
    start_ok     = 1'b0;
    unique case (mode) inside
      psched_pkg::MODE_CREATE: begin
        if ({1'b0, prio} >= psched_pkg::COUNT_W'(NUM_PRIO)) begin
          apply_status = psched_pkg::ST_IGNORED;
        end else if (task_count >= psched_pkg::COUNT_W'(MAX_TASKS)) begin
          apply_status = psched_pkg::ST_FULL;
        end else begin
          create_ok = 1'b1;
        end
      end
      psched_pkg::MODE_DELAY: begin
        if (blocked) begin
          apply_status = psched_pkg::ST_IGNORED;
        end else if (ticks != '0) begin
          delay_ok   = 1'b1;
          apply_scan = 1'b1;
        end
      end
      psched_pkg::MODE_TICK: begin
        if (!running) begin
          apply_status = psched_pkg::ST_IGNORED;
        end else begin
          apply_scan = 1'b1;
          apply_kind = SCAN_TICK;
        end
      end
      psched_pkg::MODE_RESCHED, psched_pkg::MODE_INT_EXIT: begin
        if ((mode == psched_pkg::MODE_INT_EXIT && !running) || blocked) begin
          apply_status = psched_pkg::ST_IGNORED;
        end else begin
          apply_scan = 1'b1;
        end
      end
      psched_pkg::MODE_START: begin
        if (running) begin
          apply_status = psched_pkg::ST_IGNORED;
        end else begin
          start_ok   = 1'b1;
          apply_scan = 1'b1;
          apply_kind = SCAN_START;
        end
      end
      default: begin
        apply_status = psched_pkg::ST_IGNORED;
      end
    endcase
  end

  assign req_ready = (state == S_IDLE);

  assign chain[0] = '{valid: (state == S_LAUNCH), tick: (scan_kind == SCAN_TICK),
                      found: 1'b0, idx: '0};

  assign pick         = chain[NUM_PRIO].found ? chain[NUM_PRIO].idx : '0;
  assign pick_changes = (pick != current_prio);

  for (genvar i = 0; i < NUM_PRIO; i++) begin : g_cell
    always_comb begin
      cmd[i].set_ready  = (state == S_APPLY) && create_ok && (prio == psched_pkg::idx_t'(i));
      cmd[i].clr_count  = cmd[i].set_ready;
      cmd[i].clr_ready  = (state == S_APPLY) && delay_ok &&
                          (current_prio == psched_pkg::idx_t'(i));
      cmd[i].load_count = cmd[i].clr_ready;
    end

    psched_cell #(
      .DELAY_WIDTH (DELAY_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd[i]),
      .load_value (ticks),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1]),
      .ready_bit  (ready_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      task_count   <= '0;
      current_prio <= '0;
      running      <= 1'b0;
      switch_count <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= apply_scan ? S_LAUNCH : S_FIN;
          if (create_ok) begin
            task_count <= task_count + 1'b1;
          end
          if (start_ok) begin
            running <= 1'b1;
          end
        end
        S_LAUNCH: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (chain[NUM_PRIO].valid) begin
            state <= S_FIN;
            if (scan_kind == SCAN_START) begin
              current_prio <= pick;
            end else if (scan_kind == SCAN_SWITCH && pick_changes) begin
              current_prio <= pick;
              switch_count <= switch_count + 1'b1;
            end
          end
        end
        S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      mode    <= req.mode;
      prio    <= req.task_prio;
      ticks   <= req.delay_ticks[DELAY_WIDTH-1:0];
      blocked <= req.int_active | req.sched_locked;
    end
    if (state == S_APPLY) begin
      status    <= apply_status;
      sw        <= 1'b0;
      scan_kind <= apply_kind;
    end
    if (state == S_SCAN && chain[NUM_PRIO].valid) begin
      sw <= (scan_kind == SCAN_SWITCH) && pick_changes;
    end
    if (state == S_FIN && (!rsp_valid || rsp_ready)) begin
      rsp.switch_needed <= sw;
      rsp.next_prio     <= current_prio;
      rsp.ready_bits    <= 8'(ready_vec);
      rsp.status        <= status;
      rsp.switch_total  <= switch_count;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/psched_checker.sv -----
// port-level checks on the priority scheduler, bound to the top level
`default_nettype none

module psched_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_ready,
  input wire psched_pkg::req_t req,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire psched_pkg::rsp_t rsp
);

  // a held result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  // one event in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req taken while busy");

  // a switch only comes with a good status
  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.switch_needed |-> rsp.status == psched_pkg::ST_OK)
    else $error("switch with bad status");

  // a switch lands on a ready priority or on the idle default
  a_switch_target: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.switch_needed |->
      rsp.ready_bits[rsp.next_prio] || rsp.ready_bits == 8'd0)
    else $error("switch to priority not ready");

endmodule

bind priority_ready_scheduler_top psched_checker u_psched_checker (.*);

`default_nettype wire

// ----- sim/sched_event_checker.sv -----
// checker for the priority scheduler: predicts each event's result and compares transfers
module sched_event_checker
  import psched_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   outstanding,
  output int   events_taken,
  output int   results_checked,
  output int   switch_events,
  output int   ignored_events,
  output int   full_events
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  ready_q;
  logic [31:0] delay_q [8];
  logic [3:0]  task_q;
  logic [2:0]  cur_q;
  logic        running_q;
  logic [31:0] switch_q;

  rsp_t sched_outcomes[$];
  int   mismatches;
  int   n_events;
  int   n_checked;
  int   n_switches;
  int   n_ignored;
  int   n_full;

  function automatic logic [2:0] lowest_ready();
    for (int i = 0; i < NUM_PRIO_DEF; i++) begin
      if (ready_q[i]) return 3'(i);
    end
    return 3'd0;
  endfunction

  function automatic logic pick_and_switch();
    logic [2:0] p;
    p = lowest_ready();
    if (p != cur_q) begin
      switch_q = switch_q + 32'd1;
      cur_q    = p;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rsp_t apply_event(input req_t r);
    rsp_t       o;
    logic       blocked;
    logic       sw;
    logic [1:0] st;
    blocked = r.int_active | r.sched_locked;
    sw      = 1'b0;
    st      = ST_OK;
    case (r.mode)
      MODE_CREATE: begin
        if (int'(r.task_prio) >= NUM_PRIO_DEF) begin
          st = ST_IGNORED;
        end else if (int'(task_q) >= MAX_TASKS_DEF) begin
          st = ST_FULL;
        end else begin
          delay_q[r.task_prio] = '0;
          ready_q[r.task_prio] = 1'b1;
          task_q = task_q + 4'd1;
        end
      end
      MODE_DELAY: begin
        if (blocked) begin
          st = ST_IGNORED;
        end else if (r.delay_ticks != '0) begin
          ready_q[cur_q] = 1'b0;
          delay_q[cur_q] = r.delay_ticks;
          sw = pick_and_switch();
        end
      end
      MODE_TICK: begin
        if (!running_q) begin
          st = ST_IGNORED;
        end else begin
          for (int i = 0; i < NUM_PRIO_DEF; i++) begin
            if (delay_q[i] != '0) begin
              delay_q[i] = delay_q[i] - 32'd1;
              if (delay_q[i] == '0) ready_q[i] = 1'b1;
            end
          end
        end
      end
      MODE_RESCHED, MODE_INT_EXIT: begin
        if ((r.mode == MODE_INT_EXIT && !running_q) || blocked) st = ST_IGNORED;
        else sw = pick_and_switch();
      end
      MODE_START: begin
        if (running_q) begin
          st = ST_IGNORED;
        end else begin
          running_q = 1'b1;
          cur_q     = lowest_ready();
        end
      end
      default: st = ST_IGNORED;
    endcase
    if (sw) n_switches++;
    if (st == ST_IGNORED) n_ignored++;
    if (st == ST_FULL) n_full++;
    o.switch_needed = sw;
    o.next_prio     = cur_q;
    o.ready_bits    = ready_q;
    o.status        = st;
    o.switch_total  = switch_q;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (sched_outcomes.size() == 0) begin
      report_mismatch("result transfer with nothing outstanding", longint'(got), 0);
      return;
    end
    want = sched_outcomes.pop_front();
    n_checked++;
    if (got.switch_needed !== want.switch_needed)
      report_mismatch("switch_needed", got.switch_needed, want.switch_needed);
    if (got.next_prio !== want.next_prio)
      report_mismatch("next_prio", got.next_prio, want.next_prio);
    if (got.ready_bits !== want.ready_bits)
      report_mismatch("ready_bits", got.ready_bits, want.ready_bits);
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
    if (got.switch_total !== want.switch_total)
      report_mismatch("switch_total", got.switch_total, want.switch_total);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ready_q    = '0;
      task_q     = '0;
      cur_q      = '0;
      running_q  = 1'b0;
      switch_q   = '0;
      mismatches = 0;
      n_events   = 0;
      n_checked  = 0;
      n_switches = 0;
      n_ignored  = 0;
      n_full     = 0;
      for (int i = 0; i < NUM_PRIO_DEF; i++) delay_q[i] = '0;
      sched_outcomes.delete();
    end else begin
      if (rsp_valid && rsp_ready) check_result(rsp);
      if (req_valid && req_ready) begin
        sched_outcomes.push_back(apply_event(req));
        n_events++;
      end
    end
    fail_count      <= mismatches;
    outstanding     <= sched_outcomes.size();
    events_taken    <= n_events;
    results_checked <= n_checked;
    switch_events   <= n_switches;
    ignored_events  <= n_ignored;
    full_events     <= n_full;
  end

endmodule

// ----- sim/priority_ready_scheduler_top_tb.sv -----
// testbench top for the priority scheduler: clock, reset, event stimulus and verdict
module priority_ready_scheduler_top_tb;
  import psched_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int RANDOM_EVENTS  = 650;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 24;
  localparam int STALL_LIMIT    = 4000;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  logic rx_hold_req;
  logic tx_calm;
  int   holds_done;
  int   idle_cycles;

  int fail_count;
  int outstanding;
  int events_taken;
  int results_checked;
  int switch_events;
  int ignored_events;
  int full_events;

  always #6 clk = ~clk;

  priority_ready_scheduler_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  sched_event_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .events_taken    (events_taken),
    .results_checked (results_checked),
    .switch_events   (switch_events),
    .ignored_events  (ignored_events),
    .full_events     (full_events)
  );

  function automatic int idle_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic req_t sched_event(input logic [2:0] mode, input logic [2:0] prio,
                                       input logic [31:0] ticks, input logic ia,
                                       input logic sl);
    req_t r;
    r.mode         = mode;
    r.task_prio    = prio;
    r.delay_ticks  = ticks;
    r.int_active   = ia;
    r.sched_locked = sl;
    return r;
  endfunction

  function automatic req_t random_event();
    req_t r;
    int   k;
    int   t;
    k = $urandom_range(0, 99);
    t = $urandom_range(0, 99);
    r.task_prio    = 3'($urandom_range(0, 7));
    r.int_active   = ($urandom_range(0, 99) < 15);
    r.sched_locked = ($urandom_range(0, 99) < 15);
    if (t < 8) r.delay_ticks = '0;
    else if (t < 90) r.delay_ticks = 32'($urandom_range(1, 6));
    else if (t < 95) r.delay_ticks = 32'($urandom_range(7, 40));
    else r.delay_ticks = $urandom();
    if (k < 35) r.mode = MODE_TICK;
    else if (k < 57) r.mode = MODE_DELAY;
    else if (k < 73) r.mode = MODE_RESCHED;
    else if (k < 86) r.mode = MODE_INT_EXIT;
    else if (k < 94) r.mode = MODE_CREATE;
    else if (k < 97) r.mode = MODE_START;
    else if (k < 99) r.mode = MODE_SPARE_LO;
    else r.mode = MODE_SPARE_HI;
    return r;
  endfunction

  task automatic send_event(input req_t r);
    int gap;
    gap = tx_calm ? 0 : idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // receiver: random back-pressure, calm stretches and requested long hold-offs
  initial begin
    int lo;
    rsp_ready  = 1'b0;
    holds_done = 0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rsp_ready   <= 1'b0;
        rx_hold_req <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if ($urandom_range(0, 11) == 0) begin
        rsp_ready <= 1'b1;
        repeat (50) @(posedge clk);
      end else begin
        lo = idle_len();
        if (lo > 0) begin
          rsp_ready <= 1'b0;
          repeat (lo) @(posedge clk);
        end
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, outstanding);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    rx_hold_req = 1'b0;
    tx_calm     = 1'b0;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_event(sched_event(MODE_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_event(sched_event(MODE_INT_EXIT, 3'd0, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_DELAY, 3'd0, 32'd5, 1'b0, 1'b0));
    send_event(sched_event(MODE_SPARE_LO, 3'd0, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_SPARE_HI, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_event(sched_event(MODE_CREATE, 3'd7, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_CREATE, 3'd0, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_START, 3'd0, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_START, 3'd0, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_DELAY, 3'd0, 32'd9, 1'b1, 1'b0));
    send_event(sched_event(MODE_DELAY, 3'd0, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_DELAY, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_event(sched_event(MODE_CREATE, 3'd3, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_RESCHED, 3'd0, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_RESCHED, 3'd0, 32'd0, 1'b0, 1'b1));
    send_event(sched_event(MODE_INT_EXIT, 3'd0, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_DELAY, 3'd0, 32'd1, 1'b0, 1'b0));
    send_event(sched_event(MODE_TICK, 3'd0, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_INT_EXIT, 3'd0, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_CREATE, 3'd3, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_CREATE, 3'd1, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_CREATE, 3'd2, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_CREATE, 3'd4, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_CREATE, 3'd5, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_CREATE, 3'd6, 32'd0, 1'b0, 1'b0));
    send_event(sched_event(MODE_RESCHED, 3'd0, 32'd0, 1'b0, 1'b0));

    for (n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (n == 150 || n == 450) rx_hold_req <= 1'b1;
      send_event(random_event());
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d scheduler events in, %0d results compared, %0d context switches seen",
             events_taken, results_checked, switch_events);
    $display("%0d events ignored, %0d creates refused on a full table, %0d long output stalls",
             ignored_events, full_events, holds_done);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/psched_pkg.sv
hw/rtl/psched_cell.sv
hw/rtl/priority_ready_scheduler_top.sv
hw/rtl/psched_checker.sv
sim/sched_event_checker.sv
sim/priority_ready_scheduler_top_tb.sv
